// ----- hw/rtl/rgbwc_pkg.sv -----
`timescale 1ns / 1ps

package rgbwc_pkg;

    localparam int DEF_MAX_WIDTH     = 1024;
    localparam int DEF_MAX_TAPS_SIDE = 5;
    localparam int MAX_HEIGHT        = 4096;
    localparam int HGT_W             = 13;
    localparam int ROW_W             = 14;
    localparam int OROW_W            = 12;
    localparam int SUM_W             = 16;
    localparam int DEN_W             = 7;
    localparam int RCP_W             = 21;
    localparam int RCP_SHIFT         = 24;
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 13;

    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_TYPE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDE_KERNEL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd3;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef struct packed {
        logic       opcode;
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       frame_last;
    } out_item_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] red;
        logic signed [SUM_W-1:0] green;
        logic signed [SUM_W-1:0] blue;
    } partial_t;

    // box, triangle, gaussian, sinc
    localparam int KERN3 [4][9] = '{
        '{1, 1, 1, 1, 1, 1, 1, 1, 1},
        '{1, 2, 1, 2, 4, 2, 1, 2, 1},
        '{1, 2, 1, 2, 5, 2, 1, 2, 1},
        '{2, 3, 2, 3, 4, 3, 2, 3, 2}
    };

    localparam int KERN5 [4][25] = '{
        '{1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1},
        '{1, 2, 3, 2, 1, 2, 4, 6, 4, 2, 3, 6, 9, 6, 3, 2, 4, 6, 4, 2, 1, 2, 3, 2, 1},
        '{1, 1, 1, 1, 1, 1, 2, 4, 2, 1, 1, 4, 10, 4, 1, 1, 2, 4, 2, 1, 1, 1, 1, 1, 1},
        '{-2, -1, 0, -1, -2, -1, 4, 6, 4, -1, 0, 6, 9, 6, 0, -1, 4, 6, 4, -1,
          -2, -1, 0, -1, -2}
    };

    localparam int DEN3 [4] = '{9, 16, 17, 24};
    localparam int DEN5 [4] = '{25, 81, 50, 33};
    // ceil(2^24 / den)
    localparam int RCP3 [4] = '{1864136, 1048576, 986896, 699051};
    localparam int RCP5 [4] = '{671089, 207127, 335545, 508401};

    function automatic logic [4:0] kernel_weight(input logic [1:0] kt, input logic wide,
                                                 input int dy, input int dx);
        logic [4:0] w;
        w = '0;
        if (wide) begin
            if (dy >= 0 && dy < 5 && dx >= 0 && dx < 5)
            begin
                w = 5'(KERN5[kt][dy * 5 + dx]);
            end
        end
        else if (dy >= 0 && dy < 3 && dx >= 0 && dx < 3)
        begin
            w = 5'(KERN3[kt][dy * 3 + dx]);
        end
        return w;
    endfunction

    function automatic logic [DEN_W-1:0] kernel_den(input logic [1:0] kt, input logic wide);
        return wide ? DEN_W'(DEN5[kt]) : DEN_W'(DEN3[kt]);
    endfunction

    function automatic logic [RCP_W-1:0] kernel_recip(input logic [1:0] kt, input logic wide);
        return wide ? RCP_W'(RCP5[kt]) : RCP_W'(RCP3[kt]);
    endfunction

endpackage

// ----- hw/rtl/rgbwc_ram.sv -----
`timescale 1ns / 1ps

module rgbwc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/rgbwc_cell.sv -----
`timescale 1ns / 1ps

module rgbwc_cell #(
    parameter int TAPS = rgbwc_pkg::DEF_MAX_TAPS_SIDE
) (
    input  logic                               clk,
    input  logic                               shift,
    input  logic                               en,
    input  rgbwc_pkg::pixel_t [TAPS-1:0]       col_in,
    input  logic [TAPS-1:0][4:0]               weight,
    input  logic [TAPS-1:0]                    row_ok,
    input  logic                               col_ok,
    output rgbwc_pkg::pixel_t [TAPS-1:0]       col_out,
    output rgbwc_pkg::partial_t                part
);

    localparam int SW = rgbwc_pkg::SUM_W;

    rgbwc_pkg::pixel_t [TAPS-1:0] col_reg;
    rgbwc_pkg::partial_t          part_reg;
    rgbwc_pkg::partial_t          part_next;

    always_comb
    begin
        rgbwc_pkg::pixel_t     px;
        logic signed [4:0]     wk;
        part_next = '0;
        for (int k = 0; k < TAPS; k++)
        begin
            px = (row_ok[k] && col_ok) ? col_reg[k] : '0;
            wk = $signed(weight[k]);
            part_next.red   = part_next.red   + SW'(wk) * SW'($signed({1'b0, px.red}));
            part_next.green = part_next.green + SW'(wk) * SW'($signed({1'b0, px.green}));
            part_next.blue  = part_next.blue  + SW'(wk) * SW'($signed({1'b0, px.blue}));
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            col_reg <= col_in;
        end
        if (en)
        begin
            part_reg <= part_next;
        end
    end

    assign col_out = col_reg;
    assign part    = part_reg;

endmodule

// ----- hw/rtl/rgb_window_convolution_filter.sv -----
`timescale 1ns / 1ps

// channel | dir | handshake            | payload
// in      | in  | in_valid / in_ready  | in_data  (opcode, in_red, in_green, in_blue)
// out     | out | out_valid / out_ready| out_data (out_red, out_green, out_blue, frame_last)
// cfg     | in  | cfg_we               | cfg_index, cfg_wdata
//
// One item per clock unless the output stalls; results pass stages A, W, C, D, E to out_data.
// The rate is set by the dual-port line RAMs, one read and one write per column.
// Reset clears control state; line RAM contents are never cleared.
// An output stall freezes the whole pipeline and drops in_ready the same cycle.

module rgb_window_convolution_filter #(
    parameter int MAX_WIDTH     = rgbwc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_TAPS_SIDE = rgbwc_pkg::DEF_MAX_TAPS_SIDE
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  rgbwc_pkg::in_item_t                   in_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output rgbwc_pkg::out_item_t                  out_data,
    input  logic                                  cfg_we,
    input  logic [rgbwc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rgbwc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    localparam int TAPS   = MAX_TAPS_SIDE;
    localparam int NLINE  = TAPS - 1;
    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int CNT_W  = $clog2(MAX_WIDTH + 1);
    localparam int DLY_W  = CNT_W + 2;
    localparam int HGT_W  = rgbwc_pkg::HGT_W;
    localparam int ROW_W  = rgbwc_pkg::ROW_W;
    localparam int OROW_W = rgbwc_pkg::OROW_W;
    localparam int SW     = rgbwc_pkg::SUM_W;
    localparam int PROD_W = (SW - 1) + rgbwc_pkg::RCP_W;
    localparam int PIX_W  = $bits(rgbwc_pkg::pixel_t);

    // configuration
    logic [1:0]       kernel_type_reg;
    logic             wide_kernel_reg;
    logic [10:0]      image_width_reg;
    logic [HGT_W-1:0] image_height_reg;
    logic             cfg_hit;

    always_comb
    begin
        unique case (cfg_index)
            rgbwc_pkg::REG_KERNEL_TYPE,
            rgbwc_pkg::REG_WIDE_KERNEL,
            rgbwc_pkg::REG_IMAGE_WIDTH,
            rgbwc_pkg::REG_IMAGE_HEIGHT: cfg_hit = cfg_we;
            default:                     cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_type_reg  <= 2'd0;
            wide_kernel_reg  <= 1'b0;
            image_width_reg  <= 11'd640;
            image_height_reg <= 13'd480;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rgbwc_pkg::REG_KERNEL_TYPE:  kernel_type_reg  <= cfg_wdata[1:0];
                rgbwc_pkg::REG_WIDE_KERNEL:  wide_kernel_reg  <= cfg_wdata[0];
                rgbwc_pkg::REG_IMAGE_WIDTH:  image_width_reg  <= cfg_wdata[10:0];
                rgbwc_pkg::REG_IMAGE_HEIGHT: image_height_reg <= cfg_wdata[HGT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    logic             wide_on;
    logic [1:0]       half;
    int               side;
    logic [CNT_W-1:0] w_eff;
    logic [HGT_W-1:0] h_eff;
    logic [DLY_W-1:0] delay;

    assign wide_on = wide_kernel_reg && (TAPS >= 5);
    assign half    = wide_on ? 2'd2 : 2'd1;
    assign side    = wide_on ? 5 : 3;

    always_comb
    begin
        if (image_width_reg == '0)
        begin
            w_eff = CNT_W'(1);
        end
        else if (32'(image_width_reg) > 32'(MAX_WIDTH))
        begin
            w_eff = CNT_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = CNT_W'(image_width_reg);
        end
        if (image_height_reg == '0)
        begin
            h_eff = HGT_W'(1);
        end
        else if (32'(image_height_reg) > 32'(rgbwc_pkg::MAX_HEIGHT))
        begin
            h_eff = HGT_W'(rgbwc_pkg::MAX_HEIGHT);
        end
        else
        begin
            h_eff = image_height_reg;
        end
        delay = wide_on ? (DLY_W'({w_eff, 1'b0}) + DLY_W'(2)) : (DLY_W'(w_eff) + DLY_W'(1));
    end

    // pipeline control
    logic out_valid_reg;
    logic en;
    logic acc;
    logic take;
    logic frame_done;
    logic emit;
    logic last_now;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;
    assign acc      = in_valid && in_ready;

    // raster counters
    logic [ADDR_W-1:0] in_col_reg,    in_col_next;
    logic [ROW_W-1:0]  in_row_reg,    in_row_next;
    logic [DLY_W-1:0]  start_cnt_reg, start_cnt_next;
    logic [ADDR_W-1:0] o_col_reg,     o_col_next;
    logic [OROW_W-1:0] o_row_reg,     o_row_next;

    assign frame_done = in_row_reg >= ROW_W'(h_eff);
    assign take       = acc && !(in_data.opcode == rgbwc_pkg::OP_FLUSH && !frame_done);
    assign emit       = start_cnt_reg == delay;
    assign last_now   = emit && (HGT_W'(o_row_reg) == h_eff - HGT_W'(1))
                        && (CNT_W'(o_col_reg) == w_eff - CNT_W'(1));

    always_comb
    begin
        in_col_next    = in_col_reg;
        in_row_next    = in_row_reg;
        start_cnt_next = start_cnt_reg;
        o_col_next     = o_col_reg;
        o_row_next     = o_row_reg;
        if (cfg_hit || (take && last_now))
        begin
            in_col_next    = '0;
            in_row_next    = '0;
            start_cnt_next = '0;
            o_col_next     = '0;
            o_row_next     = '0;
        end
        else if (take)
        begin
            if (CNT_W'(in_col_reg) == w_eff - CNT_W'(1))
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + ROW_W'(1);
            end
            else
            begin
                in_col_next = in_col_reg + ADDR_W'(1);
            end
            if (!emit)
            begin
                start_cnt_next = start_cnt_reg + DLY_W'(1);
            end
            else if (CNT_W'(o_col_reg) == w_eff - CNT_W'(1))
            begin
                o_col_next = '0;
                o_row_next = o_row_reg + OROW_W'(1);
            end
            else
            begin
                o_col_next = o_col_reg + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            start_cnt_reg <= '0;
            o_col_reg     <= '0;
            o_row_reg     <= '0;
        end
        else
        begin
            in_col_reg    <= in_col_next;
            in_row_reg    <= in_row_next;
            start_cnt_reg <= start_cnt_next;
            o_col_reg     <= o_col_next;
            o_row_reg     <= o_row_next;
        end
    end

    // stage A: line RAM read in flight
    logic              a_valid_reg;
    rgbwc_pkg::pixel_t a_pix_reg;
    logic [ADDR_W-1:0] a_col_reg;
    logic              a_emit_reg;
    logic              a_last_reg;
    logic [OROW_W-1:0] a_orow_reg;
    logic [ADDR_W-1:0] a_ocol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            a_pix_reg  <= (in_data.opcode == rgbwc_pkg::OP_PIXEL && !frame_done)
                          ? {in_data.in_red, in_data.in_green, in_data.in_blue} : '0;
            a_col_reg  <= in_col_reg;
            a_emit_reg <= emit;
            a_last_reg <= last_now;
            a_orow_reg <= o_row_reg;
            a_ocol_reg <= o_col_reg;
        end
    end

    // line RAMs, one row of delay each; same-column back-to-back goes via bypass
    rgbwc_pkg::pixel_t [NLINE-1:0] rd;
    rgbwc_pkg::pixel_t [NLINE-1:0] rdc;
    rgbwc_pkg::pixel_t [NLINE-1:0] wdata;
    rgbwc_pkg::pixel_t [NLINE-1:0] byp_data_reg;
    logic                          byp_reg;
    logic                          ram_we;

    assign ram_we = a_valid_reg && en;

    always_comb
    begin
        for (int m = 0; m < NLINE; m++)
        begin
            rdc[m] = byp_reg ? byp_data_reg[m] : rd[m];
        end
        wdata[0] = a_pix_reg;
        for (int m = 1; m < NLINE; m++)
        begin
            wdata[m] = rdc[m-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_reg <= 1'b0;
        end
        else if (take)
        begin
            byp_reg <= ram_we && (a_col_reg == in_col_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byp_data_reg <= wdata;
        end
    end

    for (genvar m = 0; m < NLINE; m++)
    begin : g_line
        rgbwc_ram #(
            .WIDTH (PIX_W),
            .DEPTH (MAX_WIDTH)
        ) u_line (
            .clk   (clk),
            .we    (ram_we),
            .waddr (a_col_reg),
            .wdata (wdata[m]),
            .re    (take),
            .raddr (in_col_reg),
            .rdata (rd[m])
        );
    end

    // stage W: window cells
    rgbwc_pkg::pixel_t [TAPS-1:0] new_col;
    logic [TAPS-1:0]              row_ok_a, col_ok_a;
    logic [TAPS-1:0]              row_ok_reg, col_ok_reg;
    logic                         w_valid_reg, w_emit_reg, w_last_reg;
    logic                         shift;

    assign shift = a_valid_reg && en;

    always_comb
    begin
        logic signed [15:0] r;
        logic signed [15:0] c;
        new_col[0] = a_pix_reg;
        for (int k = 1; k < TAPS; k++)
        begin
            new_col[k] = rdc[k-1];
        end
        for (int k = 0; k < TAPS; k++)
        begin
            r = 16'(a_orow_reg) + 16'(half) - 16'(k);
            c = 16'(a_ocol_reg) + 16'(half) - 16'(k);
            row_ok_a[k] = (r >= 0) && (r < $signed(16'(h_eff)));
            col_ok_a[k] = (c >= 0) && (c < $signed(16'(w_eff)));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            w_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            w_emit_reg <= a_emit_reg;
            w_last_reg <= a_last_reg;
            row_ok_reg <= row_ok_a;
            col_ok_reg <= col_ok_a;
        end
    end

    logic [TAPS-1:0][4:0]          cell_w [TAPS];
    rgbwc_pkg::pixel_t [TAPS-1:0]  cell_col [TAPS];
    rgbwc_pkg::partial_t           cell_part [TAPS];

    always_comb
    begin
        for (int j = 0; j < TAPS; j++)
        begin
            for (int k = 0; k < TAPS; k++)
            begin
                cell_w[j][k] = rgbwc_pkg::kernel_weight(kernel_type_reg, wide_on,
                                                        side - 1 - k, side - 1 - j);
            end
        end
    end

    for (genvar j = 0; j < TAPS; j++)
    begin : g_cell
        rgbwc_cell #(
            .TAPS (TAPS)
        ) u_cell (
            .clk     (clk),
            .shift   (shift),
            .en      (en),
            .col_in  ((j == 0) ? new_col : cell_col[(j == 0) ? 0 : j - 1]),
            .weight  (cell_w[j]),
            .row_ok  (row_ok_reg),
            .col_ok  (col_ok_reg[j]),
            .col_out (cell_col[j]),
            .part    (cell_part[j])
        );
    end

    // stages C..E: column sums, total, reciprocal multiply
    logic                                c_valid_reg, c_last_reg;
    logic                                d_valid_reg, d_last_reg;
    logic                                e_valid_reg, e_last_reg;
    logic signed [SW-1:0]                d_sum_reg [3];
    logic signed [SW-1:0]                d_sum_next [3];
    logic [2:0]                          e_pos_reg, e_sat_reg;
    logic [PROD_W-1:0]                   e_prod_reg [3];
    logic [rgbwc_pkg::DEN_W-1:0]         den;
    logic [rgbwc_pkg::RCP_W-1:0]         rcp;
    rgbwc_pkg::out_item_t                out_data_reg;

    assign den = rgbwc_pkg::kernel_den(kernel_type_reg, wide_on);
    assign rcp = rgbwc_pkg::kernel_recip(kernel_type_reg, wide_on);

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            d_sum_next[ch] = '0;
        end
        for (int j = 0; j < TAPS; j++)
        begin
            d_sum_next[0] = d_sum_next[0] + cell_part[j].red;
            d_sum_next[1] = d_sum_next[1] + cell_part[j].green;
            d_sum_next[2] = d_sum_next[2] + cell_part[j].blue;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            e_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            c_valid_reg   <= w_valid_reg && w_emit_reg;
            d_valid_reg   <= c_valid_reg;
            e_valid_reg   <= d_valid_reg;
            out_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_last_reg <= w_last_reg;
            d_last_reg <= c_last_reg;
            e_last_reg <= d_last_reg;
            for (int ch = 0; ch < 3; ch++)
            begin
                d_sum_reg[ch]  <= d_sum_next[ch];
                e_pos_reg[ch]  <= d_sum_reg[ch] > 0;
                e_sat_reg[ch]  <= d_sum_reg[ch] >= $signed({1'b0, den, 8'b0});
                e_prod_reg[ch] <= PROD_W'(d_sum_reg[ch][SW-2:0]) * PROD_W'(rcp);
            end
            out_data_reg.out_red    <= !e_pos_reg[0] ? 8'd0 : e_sat_reg[0] ? 8'd255
                                       : e_prod_reg[0][rgbwc_pkg::RCP_SHIFT+7:rgbwc_pkg::RCP_SHIFT];
            out_data_reg.out_green  <= !e_pos_reg[1] ? 8'd0 : e_sat_reg[1] ? 8'd255
                                       : e_prod_reg[1][rgbwc_pkg::RCP_SHIFT+7:rgbwc_pkg::RCP_SHIFT];
            out_data_reg.out_blue   <= !e_pos_reg[2] ? 8'd0 : e_sat_reg[2] ? 8'd255
                                       : e_prod_reg[2][rgbwc_pkg::RCP_SHIFT+7:rgbwc_pkg::RCP_SHIFT];
            out_data_reg.frame_last <= e_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_frame_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (take && last_now) |=> (in_row_reg == '0 && o_row_reg == '0 && o_col_reg == '0))
        else $error("counters not cleared after last output of frame");

    a_start_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        start_cnt_reg <= delay)
        else $error("start counter ran past the window delay");

    a_out_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        CNT_W'(o_col_reg) < w_eff)
        else $error("output column beyond frame width");

endmodule

// ----- tb/tb_rgb_window_convolution_filter.sv -----
`timescale 1ns / 1ps

module tb_rgb_window_convolution_filter;
    import rgbwc_pkg::*;

    localparam int LIMIT_CYCLES = 1000000;
    localparam int PAT_RAND  = 0;
    localparam int PAT_CHECK = 1;
    localparam int PAT_FULL  = 2;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    in_item_t              in_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_item_t             out_data;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    rgb_window_convolution_filter DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #10 clk = ~clk;

    in_item_t  pixel_queue[$];
    out_item_t filtered_queue[$];
    bit        failed = 1'b0;
    int        cyc = 0;
    int        pixels_sent = 0;

    // filter state as seen from outside
    logic [1:0]  f_kernel;
    logic        f_wide;
    logic [10:0] f_width;
    logic [12:0] f_height;
    pixel_t      line_mem [8][1024];
    int          col_pos, row_pos, out_pos;

    function automatic int width_eff(input int v);
        return (v == 0) ? 1 : ((v > 1024) ? 1024 : v);
    endfunction

    function automatic int height_eff(input int v);
        return (v == 0) ? 1 : ((v > MAX_HEIGHT) ? MAX_HEIGHT : v);
    endfunction

    function automatic logic [7:0] clamp_div(input int s, input int d);
        int v;
        v = s / d;
        return (v < 0) ? 8'd0 : ((v > 255) ? 8'd255 : 8'(v));
    endfunction

    task automatic filter_step(input in_item_t it);
        int w, hgt, total, side, half, dly, pos, orow, ocol, r, c, k, den;
        int s_r, s_g, s_b;
        pixel_t px;
        out_item_t o;
        w = width_eff(f_width);
        hgt = height_eff(f_height);
        total = w * hgt;
        side = f_wide ? 5 : 3;
        half = side / 2;
        dly = half * w + half;
        pos = row_pos * w + col_pos;
        den = f_wide ? DEN5[f_kernel] : DEN3[f_kernel];
        if (it.opcode == OP_FLUSH) begin
            if (pos < total)
                return;
        end
        else if (pos < total) begin
            line_mem[row_pos % 8][col_pos] = {it.in_red, it.in_green, it.in_blue};
        end
        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
        if (pos < dly)
            return;
        orow = out_pos / w;
        ocol = out_pos % w;
        s_r = 0; s_g = 0; s_b = 0;
        for (int t = 0; t < side * side; t++) begin
            r = orow + t / side;
            c = ocol + t % side;
            px = '0;
            if (r >= half && c >= half && r - half < hgt && c - half < w)
                px = line_mem[(r - half) % 8][c - half];
            k = f_wide ? KERN5[f_kernel][t] : KERN3[f_kernel][t];
            s_r += k * int'(px.red);
            s_g += k * int'(px.green);
            s_b += k * int'(px.blue);
        end
        out_pos++;
        o.out_red = clamp_div(s_r, den);
        o.out_green = clamp_div(s_g, den);
        o.out_blue = clamp_div(s_b, den);
        o.frame_last = (out_pos >= total);
        filtered_queue.push_back(o);
        if (o.frame_last) begin
            col_pos = 0; row_pos = 0; out_pos = 0;
        end
    endtask

    task automatic check_field(input string name, input int e, input int a);
        if (e != a) begin
            $display("%0t: %s expected %0d got %0d", $time, name, e, a);
            failed = 1'b1;
        end
    endtask

    // accepted transfers
    logic taken = 1'b0;
    always @(posedge clk) begin
        if (rst_n) begin
            cyc <= cyc + 1;
            if (cyc > LIMIT_CYCLES) begin
                $display("tb_rgb_window_convolution_filter: FAIL");
                $finish;
            end
            if (out_valid && out_ready) begin
                if (filtered_queue.size() == 0) begin
                    $display("%0t: unexpected output %h", $time, out_data);
                    failed = 1'b1;
                end
                else begin
                    out_item_t e;
                    e = filtered_queue.pop_front();
                    check_field("out_red", e.out_red, out_data.out_red);
                    check_field("out_green", e.out_green, out_data.out_green);
                    check_field("out_blue", e.out_blue, out_data.out_blue);
                    check_field("frame_last", e.frame_last, out_data.frame_last);
                end
            end
            taken <= in_valid && in_ready;
            if (in_valid && in_ready)
                filter_step(in_data);
        end
    end

    // sender
    int  burst = 1, gap = 0;
    bit  sender_busy = 1'b0;
    always @(negedge clk) begin
        if ($urandom_range(0, 300) == 0)
            sender_busy = !sender_busy;
        if (!in_valid || taken) begin
            if (gap > 0) begin
                gap--;
                in_valid <= 1'b0;
            end
            else if (pixel_queue.size() > 0) begin
                in_data <= pixel_queue.pop_front();
                in_valid <= 1'b1;
                burst--;
                if (burst <= 0) begin
                    burst = $urandom_range(1, 40);
                    gap = sender_busy ? $urandom_range(0, 8) : 0;
                end
            end
            else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver
    int hold = 0, rmode = 0;
    bit long_hold_done = 1'b0;
    always @(negedge clk) begin
        if (hold > 0) begin
            hold--;
            out_ready <= 1'b0;
        end
        else begin
            if ((cyc >= 3000 && !long_hold_done) || $urandom_range(0, 4999) == 0) begin
                long_hold_done = 1'b1;
                hold = $urandom_range(150, 400);
            end
            if ($urandom_range(0, 250) == 0)
                rmode = $urandom_range(0, 2);
            case (rmode)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 3) != 0);
                default: out_ready <= $urandom_range(0, 1);
            endcase
        end
    end

    task automatic wait_idle();
        while (pixel_queue.size() > 0 || in_valid || filtered_queue.size() > 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_DATA_W'(val);
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_KERNEL_TYPE:  f_kernel = 2'(val);
            REG_WIDE_KERNEL:  f_wide = 1'(val);
            REG_IMAGE_WIDTH:  f_width = 11'(val);
            REG_IMAGE_HEIGHT: f_height = 13'(val);
            default: return;
        endcase
        col_pos = 0; row_pos = 0; out_pos = 0;
    endtask

    function automatic in_item_t make_pixel(input int pat, input int x, input int y);
        in_item_t it;
        it.opcode = OP_PIXEL;
        case (pat)
            PAT_CHECK: it[23:0] = ((x + y) & 1) ? 24'hFFFFFF : 24'h000000;
            PAT_FULL:  it[23:0] = 24'hFFFFFF;
            default:   it[23:0] = 24'($urandom);
        endcase
        return it;
    endfunction

    // noise: stray early flushes, late pixels in the flush tail, cut frames
    task automatic run_phase(input int kt, input int wide, input int wv, input int hv,
                             input int frames, input int pat, input bit noise);
        int w, hgt, tail, n;
        in_item_t it;
        wait_idle();
        write_reg(REG_KERNEL_TYPE, kt);
        write_reg(REG_WIDE_KERNEL, wide);
        write_reg(REG_IMAGE_WIDTH, wv);
        write_reg(REG_IMAGE_HEIGHT, hv);
        w = width_eff(wv);
        hgt = height_eff(hv);
        tail = (wide ? 2 : 1) * (w + 1);
        for (int f = 0; f < frames; f++) begin
            n = (noise && $urandom_range(0, 9) == 0) ? $urandom_range(0, w * hgt) : w * hgt;
            for (int p = 0; p < n; p++) begin
                if (noise && $urandom_range(0, 19) == 0) begin
                    it = 24'($urandom);
                    it.opcode = OP_FLUSH;
                    pixel_queue.push_back(it);
                end
                pixel_queue.push_back(make_pixel(pat, p % w, p / w));
                pixels_sent++;
            end
            if (n < w * hgt)
                return;
            for (int p = 0; p < tail; p++) begin
                it = 25'($urandom);
                if (!noise || $urandom_range(0, 4) != 0)
                    it.opcode = OP_FLUSH;
                pixel_queue.push_back(it);
            end
        end
    endtask

    initial begin
        f_kernel = 2'd0;
        f_wide = 1'b0;
        f_width = 11'd640;
        f_height = 13'd480;
        col_pos = 0; row_pos = 0; out_pos = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        run_phase(0, 0, 4, 3, 1, PAT_CHECK, 1'b1);
        run_phase(3, 1, 3, 2, 1, PAT_CHECK, 1'b0);
        run_phase(3, 0, 2, 2, 1, PAT_FULL, 1'b0);
        run_phase(1, 1, 0, 0, 1, PAT_FULL, 1'b0);
        run_phase(2, 1, 2, 1, 1, PAT_RAND, 1'b0);
        wait_idle();
        write_reg(3'd5, 7);
        write_reg(3'd7, 0);

        while (pixels_sent < 1500)
            run_phase($urandom_range(0, 3), $urandom_range(0, 1), $urandom_range(1, 24),
                      $urandom_range(1, 12), $urandom_range(1, 3), PAT_RAND, 1'b1);

        run_phase(3, 1, 2047, 1, 1, PAT_RAND, 1'b0);
        run_phase(2, 0, 1024, 2, 1, PAT_CHECK, 1'b0);
        run_phase(1, 1, 1, 8191, 1, PAT_RAND, 1'b0);
        run_phase(0, 1, 5, 4096, 1, PAT_RAND, 1'b0);

        wait_idle();
        repeat (20) @(posedge clk);
        if (!failed)
            $display("tb_rgb_window_convolution_filter: PASS");
        else
            $display("tb_rgb_window_convolution_filter: FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/rgbwc_pkg.sv
hw/rtl/rgbwc_ram.sv
hw/rtl/rgbwc_cell.sv
hw/rtl/rgb_window_convolution_filter.sv
tb/tb_rgb_window_convolution_filter.sv
